// ----- rtl/mie_pkg.sv -----
// Shared package for the modular inverse block.
// Holds the default width and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package mie_pkg;

    // Default operand width in bits.
    localparam int WIDTH_DEF = 16;

    // Commands from the controller to the datapath, at most one active per cycle.
    typedef struct packed {
        logic load;      // capture value and modulus, seed the coefficients
        logic div_init;  // start a division of the remainder pair
        logic div_step;  // one restoring division step
        logic update;    // shift the remainder and coefficient pairs
        logic finish;    // reduce the coefficient and register the result
    } mie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r2_zero;   // current divisor is zero, the loop is over
    } mie_status_t;

endpackage

// ----- rtl/mie_ctrl.sv -----
// Controller state machine for the modular inverse block.
// Sequences the Euclid loop and the bit-serial division; depends on mie_pkg.
`timescale 1ns / 1ps

module mie_ctrl
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    output mie_cmd_t    cmd,
    input  mie_status_t status
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_UPD,
        S_FIN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Command decode from the current state.
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && start;
        cmd.div_init = (state_reg == S_TEST) && !status.r2_zero;
        cmd.div_step = (state_reg == S_DIV);
        cmd.update   = (state_reg == S_UPD);
        cmd.finish   = (state_reg == S_FIN);
    end

    // State, step counter and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // The result strobe is registered, so it rises in the cycle after the finish state.
            done_reg <= (state_reg == S_FIN);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg  <= 1'b1;
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    cnt_reg <= '0;
                    if (status.r2_zero)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    state_reg <= S_TEST;
                end
                S_FIN:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- rtl/mie_datapath.sv -----
// Datapath for the modular inverse block: remainder pair, coefficient pair,
// a restoring divider with a shift-add quotient product, and result reduction.
// Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_datapath
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] modulus,
    input  mie_cmd_t         cmd,
    output mie_status_t      status,
    output logic [WIDTH-1:0] inverse
);

    // Coefficients stay within the modulus in magnitude; two extra bits hold the sign.
    localparam int CW = WIDTH + 2;

    logic [WIDTH-1:0] r1_reg, r2_reg, mod_reg, rem_reg, dvd_reg, inv_reg;
    logic [CW-1:0]    s1_reg, s2_reg, acc_reg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_diff;
    logic             q_bit;
    logic [WIDTH-1:0] rem_next;
    logic [CW-1:0]    acc_next;
    logic [CW-1:0]    s_new;
    logic [CW-1:0]    s_fix;
    logic [WIDTH-1:0] inv_next;

    // One restoring division step; the quotient bit feeds the q*s2 product.
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[WIDTH-1]};
        rem_diff = rem_sh - {1'b0, r2_reg};
        q_bit    = (rem_sh >= {1'b0, r2_reg});
        rem_next = q_bit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        acc_next = {acc_reg[CW-2:0], 1'b0} + (q_bit ? s2_reg : {CW{1'b0}});
    end

    // Coefficient update and final reduction into 0..modulus-1.
    always_comb
    begin
        s_new = s1_reg - acc_reg;
        s_fix = s1_reg + {2'b00, mod_reg};
        if (mod_reg == '0)
            inv_next = '0;
        else if (s1_reg[CW-1])
            inv_next = s_fix[WIDTH-1:0];
        else
            inv_next = s1_reg[WIDTH-1:0];
    end

    // Datapath registers, loaded under controller command.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r1_reg  <= value;
            r2_reg  <= modulus;
            mod_reg <= modulus;
            s1_reg  <= CW'(1);
            s2_reg  <= '0;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            dvd_reg <= r1_reg;
            acc_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
        if (cmd.update)
        begin
            r1_reg <= r2_reg;
            r2_reg <= rem_reg;
            s1_reg <= s2_reg;
            s2_reg <= s_new;
        end
        if (cmd.finish)
        begin
            inv_reg <= inv_next;
        end
    end

    assign status.r2_zero = (r2_reg == '0);
    assign inverse        = inv_reg;

endmodule

// ----- rtl/modular_inverse_ext_euclid.sv -----
// Usage:
// Top level of the modular inverse block (extended Euclidean algorithm).
// Raise start with value and modulus while busy is low; that cycle is the
// transaction. busy goes high on the next cycle and stays high until the
// result is ready. The result appears on inverse, marked by done, which
// is high for a single cycle; it must be taken then, as the receiver
// cannot stall. Each transaction runs k Euclid divisions, where k is up
// to about 1.44*WIDTH + 2. Each division runs on one restoring divider
// that retires one quotient bit per cycle, between the test and update
// states; once the divisor is zero, the finish state registers the result
// and done follows. A new transaction may start in the cycle done is high.
// Reset clears the controller: busy and done go low and the block is idle.
// A modulus of one or zero gives 0; non-coprime inputs give the reduced
// Bezout coefficient of value. Depends on mie_pkg, mie_ctrl, mie_datapath.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] inverse
);

    mie_cmd_t    cmd;
    mie_status_t status;

    // Controller.
    mie_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .status(status)
    );

    // Datapath.
    mie_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .clk    (clk),
        .value  (value),
        .modulus(modulus),
        .cmd    (cmd),
        .status (status),
        .inverse(inverse)
    );

`ifndef SYNTHESIS
    // An accepted transaction makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // The result strobe comes only as the block goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done asserted outside the end of a transaction");

    // The result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the modular inverse block (extended Euclidean algorithm).
// Drives start/value/modulus transactions, predicts each inverse and checks every done strobe.
// Depends on mie_pkg and modular_inverse_ext_euclid.
`timescale 1ns / 1ps

module testbench
    import mie_pkg::*;
();

    localparam int W            = WIDTH_DEF;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [W-1:0] value;
        logic [W-1:0] modulus;
        logic [W-1:0] inverse;
    } inverse_txn_t;

    logic         clk     = 1'b0;
    logic         rst_n   = 1'b0;
    logic         start   = 1'b0;
    logic [W-1:0] value   = '0;
    logic [W-1:0] modulus = '0;
    logic         busy;
    logic         done;
    logic [W-1:0] inverse;

    inverse_txn_t pending_inverses[$];
    inverse_txn_t oldest_inverse;
    int           mismatch_count = 0;
    int           activity_count = 0;

    modular_inverse_ext_euclid #(.WIDTH(W)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .value   (value),
        .modulus (modulus),
        .done    (done),
        .inverse (inverse)
    );

    // Free-running clock, 8 ns period.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Extended Euclid on (a, m), tracking only the coefficient of a, reduced into 0..m-1.
    function automatic logic [W-1:0] ext_euclid_inverse(input logic [W-1:0] a,
                                                        input logic [W-1:0] m);
        longint r1, r2, s1, s2, q, t;
        r1 = a;
        r2 = m;
        s1 = 1;
        s2 = 0;
        if (m == '0)
            return '0;
        while (r2 != 0)
        begin
            q  = r1 / r2;
            t  = r1 - q * r2;
            r1 = r2;
            r2 = t;
            t  = s1 - q * s2;
            s1 = s2;
            s2 = t;
        end
        if (s1 < 0)
            s1 = s1 + longint'(m);
        return s1[W-1:0];
    endfunction

    function automatic bit is_coprime(input logic [W-1:0] a, input logic [W-1:0] m);
        longint x, y, t;
        x = a;
        y = m;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x == 1;
    endfunction

    // Mostly short gaps, sometimes none, a few long ones.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    // Small moduli keep the run short; full-range ones reach the top bits.
    function automatic logic [W-1:0] pick_modulus();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return W'($urandom_range(1, 16));
        else if (pick < 5)
            return W'($urandom_range(17, 4095));
        else
            return W'($urandom_range(1, 65535));
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_request(input logic [W-1:0] v, input logic [W-1:0] m);
        inverse_txn_t txn;
        txn.value   = v;
        txn.modulus = m;
        txn.inverse = ext_euclid_inverse(v, m);
        start   <= 1'b1;
        value   <= v;
        modulus <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_inverses.push_back(txn);
        activity_count++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Extremes and the named corner cases, sent back to back.
    task automatic test_directed();
        send_request(16'd0,     16'd1);      // modulus one, value zero
        send_request(16'd65535, 16'd1);      // modulus one, large value
        send_request(16'd0,     16'd65535);  // value zero
        send_request(16'd1,     16'd65535);
        send_request(16'd65534, 16'd65535);
        send_request(16'd65535, 16'd65534);  // value above modulus
        send_request(16'd65535, 16'd65535);  // value equals modulus
        send_request(16'd1,     16'd1);
        send_request(16'd3,     16'd7);
        send_request(16'd100,   16'd7);      // value above modulus
        send_request(16'd65535, 16'd2);
        send_request(16'd2,     16'd65535);
        send_request(16'd6,     16'd9);      // not coprime
        send_request(16'd255,   16'd65535);  // not coprime
        send_request(16'd32768, 16'd65535);
        send_request(16'd46368, 16'd28657);  // Fibonacci pairs give the most divisions
        send_request(16'd28657, 16'd46368);
        send_request(16'd17711, 16'd28657);
        send_request(16'd12345, 16'd65521);
        send_request(16'd32767, 16'd32768);
    endtask

    // Coprime pairs with random content; gaps are optional.
    task automatic test_random_coprime(input int count, input bit with_gaps);
        logic [W-1:0] m;
        logic [W-1:0] v;
        repeat (count)
        begin
            m = pick_modulus();
            do
            begin
                if ($urandom_range(0, 3) == 0)
                    v = W'($urandom_range(0, 65535));
                else
                    v = W'($urandom_range(0, m - 1));
            end
            while (!is_coprime(v, m));
            send_request(v, m);
            if (with_gaps)
                idle_gap(random_gap());
        end
    endtask

    // Arbitrary pairs, with a share of pairs forced to share a factor.
    task automatic test_random_noise(input int count);
        logic [W-1:0] m;
        logic [W-1:0] v;
        int           factor;
        repeat (count)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                factor = $urandom_range(2, 255);
                v = W'(factor * $urandom_range(0, 65535 / factor));
                m = W'(factor * $urandom_range(1, 65535 / factor));
            end
            else
            begin
                v = W'($urandom_range(0, 65535));
                m = pick_modulus();
            end
            send_request(v, m);
            idle_gap(random_gap());
        end
    endtask

    // Sender holds off until every outstanding result has come back, then resumes.
    task automatic test_drain_pause();
        test_random_coprime(15, 1'b0);
        start <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
        test_random_coprime(15, 1'b0);
    endtask

    // Check every result against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            activity_count++;
            if (pending_inverses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result inverse=%0d", $realtime, inverse);
            end
            else
            begin
                oldest_inverse = pending_inverses.pop_front();
                if (inverse !== oldest_inverse.inverse)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: value=%0d modulus=%0d inverse expected %0d got %0d",
                                 $realtime, oldest_inverse.value, oldest_inverse.modulus,
                                 oldest_inverse.inverse, inverse);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin
        int idle_cycles;
        int last_activity;
        idle_cycles   = 0;
        last_activity = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (activity_count != last_activity)
            begin
                last_activity = activity_count;
                idle_cycles   = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("** modular_inverse_ext_euclid: FAILED **");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_coprime(900, 1'b1);
        test_drain_pause();
        test_random_noise(400);
        test_random_coprime(200, 1'b0);
        start <= 1'b0;

        // Let outstanding results arrive, then watch for stray strobes.
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** modular_inverse_ext_euclid: PASSED **");
        else
            $display("** modular_inverse_ext_euclid: FAILED **");
        $finish;
    end

endmodule
